// ===== hw/rtl/tfe_pkg.sv =====
// ----------------------------------------------------------------------------
// Tunnel frame encoder package
// Shared constants, codes and the queue entry that links front and back.
// ----------------------------------------------------------------------------
package tfe_pkg;

   // protocol_mode codes (bit 1 set means raw pass-through)
   localparam logic [1:0] MODE_WS   = 2'd0;
   localparam logic [1:0] MODE_GRPC = 2'd1;

   localparam int WS_META_LEN   = 22;
   localparam int GRPC_META_LEN = 11;

   localparam logic [7:0] WS_FIRST_BYTE = 8'h82;
   localparam logic       WS_MASK_BIT   = 1'b1;
   localparam logic [6:0] LEN16_CODE    = 7'd126;
   localparam logic [6:0] LEN64_CODE    = 7'd127;
   localparam logic [32:0] SHORT_LIMIT  = 33'd126;
   localparam logic [32:0] MID_LIMIT    = 33'd65536;

   // header sizes in bytes for each layout
   localparam int HDR_MAX_BYTES = 36;
   localparam int HDR_BITS      = 8 * HDR_MAX_BYTES;
   localparam int CNT_W         = $clog2(HDR_MAX_BYTES + 1);
   localparam logic [CNT_W-1:0] HDR_LEN_SHORT = CNT_W'(28);
   localparam logic [CNT_W-1:0] HDR_LEN_MID   = CNT_W'(30);
   localparam logic [CNT_W-1:0] HDR_LEN_LONG  = CNT_W'(36);
   localparam logic [CNT_W-1:0] HDR_LEN_GRPC  = CNT_W'(16);

   typedef enum logic [1:0] {
      LEN_SHORT,
      LEN_MID,
      LEN_LONG
   } len_form_type;

   // one queued job: a whole header or one finished payload byte
   typedef struct packed {
      logic         hdr;
      logic         ws;
      len_form_type form;
      logic [32:0]  total;
      logic [31:0]  key;
      logic [31:0]  id;
      logic [31:0]  stream;
      logic [7:0]   kind;
      logic [15:0]  flags;
      logic [7:0]   data;
      logic         last;
   } queue_entry_type;

endpackage

// ===== hw/rtl/tunnel_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// Tunnel frame encoder
// Frames tunnel packets as masked WebSocket binary frames or gRPC messages.
//
// Request channel (req_*): a descriptor (action 0) starts a frame; payload
// bytes (action 1) follow. Response channel (rsp_*): one encoded byte per
// transfer, rsp_frame_end set on the last byte of a frame. csr_write_enable
// loads protocol_mode from csr_write_data; write it only while idle.
// A descriptor expands to 16 header bytes in gRPC mode and 28, 30 or 36 in
// WebSocket mode, one per cycle from the header shift register in the back
// end; payload bytes stream at one per cycle; both while rsp_ready is high.
// A request passes through the job queue, then the response register. The
// job queue (QUEUE_DEPTH entries) lets payload requests keep arriving while
// a header drains, so a descriptor holds the request side only once the
// queue fills. When the receiver stalls the response register holds, the
// queue fills and req_ready drops. Reset clears mode to WebSocket, the mask
// state, the open-frame flag, the queue and the response register.
// ----------------------------------------------------------------------------
module tunnel_frame_encoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [31:0] req_payload_length,
   input  logic [31:0] req_mask_value,
   input  logic [31:0] req_packet_id,
   input  logic [31:0] req_stream_number,
   input  logic [7:0]  req_packet_kind,
   input  logic [15:0] req_packet_flag_bits,
   input  logic [7:0]  req_data_byte,
   input  logic        req_final_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_frame_end
);
   import tfe_pkg::*;

   logic [1:0]      protocol_mode_ff, protocol_mode_in;
   logic            queue_full;
   logic            push;
   logic            pop;
   logic            not_empty;
   queue_entry_type push_entry;
   queue_entry_type head_entry;

   assign protocol_mode_in = csr_write_enable ? csr_write_data : protocol_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         protocol_mode_ff <= MODE_WS;
      end else begin
         protocol_mode_ff <= protocol_mode_in;
      end
   end

   tfe_front u_front (
      .clock                (clock),
      .reset                (reset),
      .protocol_mode        (protocol_mode_ff),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_action           (req_action),
      .req_payload_length   (req_payload_length),
      .req_mask_value       (req_mask_value),
      .req_packet_id        (req_packet_id),
      .req_stream_number    (req_stream_number),
      .req_packet_kind      (req_packet_kind),
      .req_packet_flag_bits (req_packet_flag_bits),
      .req_data_byte        (req_data_byte),
      .req_final_byte       (req_final_byte),
      .queue_full           (queue_full),
      .push                 (push),
      .push_entry           (push_entry)
   );

   tfe_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_entry (head_entry),
      .not_empty  (not_empty)
   );

   tfe_back u_back (
      .clock         (clock),
      .reset         (reset),
      .not_empty     (not_empty),
      .head_entry    (head_entry),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

// ===== hw/rtl/tfe_front.sv =====
// ----------------------------------------------------------------------------
// Tunnel frame encoder front end
// Accepts request items, tracks frame and mask state, queues jobs.
// ----------------------------------------------------------------------------
module tfe_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [1:0]              protocol_mode,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_action,
   input  logic [31:0]             req_payload_length,
   input  logic [31:0]             req_mask_value,
   input  logic [31:0]             req_packet_id,
   input  logic [31:0]             req_stream_number,
   input  logic [7:0]              req_packet_kind,
   input  logic [15:0]             req_packet_flag_bits,
   input  logic [7:0]              req_data_byte,
   input  logic                    req_final_byte,
   input  logic                    queue_full,
   output logic                    push,
   output tfe_pkg::queue_entry_type push_entry
);
   import tfe_pkg::*;

   logic [31:0] held_mask_ff, held_mask_in;
   logic [1:0]  mask_phase_ff, mask_phase_in;
   logic        frame_open_ff, frame_open_in;
   logic        accept;
   logic        pass_mode;
   logic        ws_mode;
   logic [32:0] total;
   logic [7:0]  key_sel;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign pass_mode = protocol_mode[1];
   assign ws_mode   = (protocol_mode == MODE_WS);
   assign total     = {1'b0, req_payload_length} +
                      (ws_mode ? 33'(WS_META_LEN) : 33'(GRPC_META_LEN));
   assign key_sel   = held_mask_ff[{~mask_phase_ff, 3'b000} +: 8];

   always_comb begin
      held_mask_in  = held_mask_ff;
      mask_phase_in = mask_phase_ff;
      frame_open_in = frame_open_ff;
      push          = 1'b0;
      push_entry.hdr    = 1'b0;
      push_entry.ws     = ws_mode;
      push_entry.total  = total;
      push_entry.key    = req_mask_value;
      push_entry.id     = req_packet_id;
      push_entry.stream = req_stream_number;
      push_entry.kind   = req_packet_kind;
      push_entry.flags  = req_packet_flag_bits;
      push_entry.data   = req_data_byte;
      push_entry.last   = req_final_byte;
      if (total < SHORT_LIMIT) begin
         push_entry.form = LEN_SHORT;
      end else if (total < MID_LIMIT) begin
         push_entry.form = LEN_MID;
      end else begin
         push_entry.form = LEN_LONG;
      end
      if (accept) begin
         if (req_action) begin
            if (pass_mode) begin
               push = 1'b1;
            end else if (frame_open_ff) begin
               push = 1'b1;
               if (ws_mode) begin
                  push_entry.data = req_data_byte ^ key_sel;
                  mask_phase_in   = mask_phase_ff + 2'd1;
               end
               if (req_final_byte) begin
                  frame_open_in = 1'b0;
               end
            end
         end else begin
            if (pass_mode) begin
               frame_open_in = 1'b0;
            end else begin
               push            = 1'b1;
               push_entry.hdr  = 1'b1;
               push_entry.last = (req_payload_length == 32'd0);
               frame_open_in   = (req_payload_length != 32'd0);
               if (ws_mode) begin
                  held_mask_in  = req_mask_value;
                  mask_phase_in = 2'(WS_META_LEN);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_mask_ff  <= '0;
         mask_phase_ff <= '0;
         frame_open_ff <= 1'b0;
      end else begin
         held_mask_ff  <= held_mask_in;
         mask_phase_ff <= mask_phase_in;
         frame_open_ff <= frame_open_in;
      end
   end

endmodule

// ===== hw/rtl/tfe_fifo.sv =====
// ----------------------------------------------------------------------------
// Tunnel frame encoder job queue
// Small register queue between the front and back ends.
// ----------------------------------------------------------------------------
module tfe_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  tfe_pkg::queue_entry_type push_entry,
   output logic                     full,
   input  logic                     pop,
   output tfe_pkg::queue_entry_type head_entry,
   output logic                     not_empty
);
   import tfe_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int QCNT_W = $clog2(DEPTH + 1);

   queue_entry_type   slots_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(DEPTH));
   assign not_empty  = (count_ff != '0);
   assign head_entry = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !not_empty))
      else $error("queue read while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not advance on write");

endmodule

// ===== hw/rtl/tfe_back.sv =====
// ----------------------------------------------------------------------------
// Tunnel frame encoder back end
// Expands queued header jobs into bytes and drives the response register.
// ----------------------------------------------------------------------------
module tfe_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     not_empty,
   input  tfe_pkg::queue_entry_type head_entry,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_frame_end
);
   import tfe_pkg::*;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [7:0]              rsp_out_byte_ff, rsp_out_byte_in;
   logic                    rsp_frame_end_ff, rsp_frame_end_in;
   logic [HDR_BITS-9:0]     shift_ff, shift_in;
   logic [CNT_W-1:0]        remain_ff, remain_in;
   logic                    last_end_ff, last_end_in;
   logic                    advance;
   logic [HDR_BITS-1:0]     hdr_vec;
   logic [CNT_W-1:0]        hdr_len;
   logic [87:0]             meta;
   logic [175:0]            ws_meta;
   logic [207:0]            ws_tail;

   assign advance = !rsp_valid_ff || rsp_ready;
   assign pop     = advance && (remain_ff == '0) && not_empty;

   // build the whole header, first byte in the top bits
   always_comb begin
      meta    = {head_entry.id, head_entry.stream, head_entry.kind, head_entry.flags};
      ws_meta = {meta, 88'h0} ^ {{5{head_entry.key}}, head_entry.key[31:16]};
      ws_tail = {head_entry.key, ws_meta};
      if (head_entry.ws) begin
         unique case (head_entry.form)
            LEN_SHORT: begin
               hdr_vec = {WS_FIRST_BYTE, WS_MASK_BIT, head_entry.total[6:0], ws_tail,
                          64'h0};
               hdr_len = HDR_LEN_SHORT;
            end
            LEN_MID: begin
               hdr_vec = {WS_FIRST_BYTE, WS_MASK_BIT, LEN16_CODE,
                          head_entry.total[15:0], ws_tail, 48'h0};
               hdr_len = HDR_LEN_MID;
            end
            default: begin
               hdr_vec = {WS_FIRST_BYTE, WS_MASK_BIT, LEN64_CODE, 31'h0,
                          head_entry.total, ws_tail};
               hdr_len = HDR_LEN_LONG;
            end
         endcase
      end else begin
         hdr_vec = {8'h00, head_entry.total[31:0], meta, 160'h0};
         hdr_len = HDR_LEN_GRPC;
      end
   end

   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      rsp_out_byte_in  = rsp_out_byte_ff;
      rsp_frame_end_in = rsp_frame_end_ff;
      shift_in         = shift_ff;
      remain_in        = remain_ff;
      last_end_in      = last_end_ff;
      if (advance) begin
         if (remain_ff != '0) begin
            // drain the rest of the current header
            rsp_valid_in     = 1'b1;
            rsp_out_byte_in  = shift_ff[HDR_BITS-9 -: 8];
            rsp_frame_end_in = (remain_ff == CNT_W'(1)) && last_end_ff;
            shift_in         = {shift_ff[HDR_BITS-17:0], 8'h00};
            remain_in        = remain_ff - 1'b1;
         end else if (not_empty) begin
            rsp_valid_in = 1'b1;
            if (head_entry.hdr) begin
               rsp_out_byte_in  = hdr_vec[HDR_BITS-1 -: 8];
               rsp_frame_end_in = 1'b0;
               shift_in         = hdr_vec[HDR_BITS-9:0];
               remain_in        = hdr_len - 1'b1;
               last_end_in      = head_entry.last;
            end else begin
               rsp_out_byte_in  = head_entry.data;
               rsp_frame_end_in = head_entry.last;
            end
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         remain_ff    <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         remain_ff    <= remain_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_out_byte_ff  <= rsp_out_byte_in;
      rsp_frame_end_ff <= rsp_frame_end_in;
      shift_ff         <= shift_in;
      last_end_ff      <= last_end_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_out_byte_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

   a_remain_bound: assert property (@(posedge clock) disable iff (reset)
      remain_ff < CNT_W'(HDR_MAX_BYTES))
      else $error("header byte count out of range");

   a_hdr_loads: assert property (@(posedge clock) disable iff (reset)
      (pop && head_entry.hdr) |=> (remain_ff != '0) && rsp_valid_ff && !rsp_frame_end_ff)
      else $error("header job did not start draining");

   a_no_early_end: assert property (@(posedge clock) disable iff (reset)
      (advance && remain_ff > CNT_W'(1)) |=> !rsp_frame_end_ff)
      else $error("frame end flagged before the last header byte");

endmodule

// ===== bench/tb_tunnel_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// Tunnel frame encoder testbench
// Drives descriptors and payload bytes with random bursts and gaps in every
// protocol mode, models the encoded byte stream (WebSocket headers, masking,
// gRPC prefix, pass-through) and checks each response transfer in order,
// while the receiver stalls on patterns of its own and twice for a long time.
// ----------------------------------------------------------------------------
module tb_tunnel_frame_encoder;
   import tfe_pkg::*;

   localparam logic       ACT_DESCRIPTOR = 1'b0;
   localparam logic       ACT_PAYLOAD    = 1'b1;
   localparam logic [1:0] MODE_RAW       = 2'd2;
   localparam logic [1:0] MODE_RAW_ALT   = 2'd3;

   localparam int SETTLE_CYCLES  = 16;
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PRINT_LIMIT    = 40;

   typedef struct {
      logic        action;
      logic [31:0] payload_length;
      logic [31:0] mask_value;
      logic [31:0] packet_id;
      logic [31:0] stream_number;
      logic [7:0]  packet_kind;
      logic [15:0] packet_flag_bits;
      logic [7:0]  data_byte;
      logic        final_byte;
   } tunnel_item_type;

   typedef struct {
      logic [7:0] value;
      logic       last;
   } frame_byte_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_EVERY_THIRD,
      STALL_HEAVY
   } stall_style_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_write_data = 2'd0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_action = 1'b0;
   logic [31:0] req_payload_length = '0;
   logic [31:0] req_mask_value = '0;
   logic [31:0] req_packet_id = '0;
   logic [31:0] req_stream_number = '0;
   logic [7:0]  req_packet_kind = '0;
   logic [15:0] req_packet_flag_bits = '0;
   logic [7:0]  req_data_byte = '0;
   logic        req_final_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_frame_end;

   tunnel_item_type pending_items[$];
   tunnel_item_type current_item;
   frame_byte_type  frame_bytes_due[$];
   frame_byte_type  oldest_due;

   // encoder state as the block should hold it
   logic [1:0]  mode_model = MODE_WS;
   logic [31:0] held_key = '0;
   logic [1:0]  key_phase = '0;
   logic        frame_busy = 1'b0;

   int error_count = 0;
   int burst_left = 0;
   int gap_left = 0;
   int holds_requested = 0;
   int holds_served = 0;
   int hold_left = 0;
   int pattern_left = 0;
   int stall_step = 0;
   int idle_cycles = 0;
   stall_style_type stall_style = STALL_NONE;

   tunnel_frame_encoder DUT (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_action           (req_action),
      .req_payload_length   (req_payload_length),
      .req_mask_value       (req_mask_value),
      .req_packet_id        (req_packet_id),
      .req_stream_number    (req_stream_number),
      .req_packet_kind      (req_packet_kind),
      .req_packet_flag_bits (req_packet_flag_bits),
      .req_data_byte        (req_data_byte),
      .req_final_byte       (req_final_byte),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_out_byte         (rsp_out_byte),
      .rsp_frame_end        (rsp_frame_end)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_LIMIT)
         $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic logic [7:0] key_byte_at(input logic [31:0] key, input logic [1:0] phase);
      return 8'(key >> (24 - 8 * int'(phase)));
   endfunction

   task automatic due_byte(input logic [7:0] value, input logic last);
      frame_byte_type fb;
      fb.value = value;
      fb.last  = last;
      frame_bytes_due = {frame_bytes_due, fb};
   endtask

   // Expected output bytes for one accepted request.
   task automatic encode_request(input tunnel_item_type it);
      logic [7:0]  meta [WS_META_LEN];
      logic [63:0] ws_total;
      logic [31:0] grpc_total;
      logic [7:0]  b;
      logic        raw;
      raw = (mode_model != MODE_WS) && (mode_model != MODE_GRPC);
      if (it.action == ACT_PAYLOAD) begin
         if (raw) begin
            due_byte(it.data_byte, it.final_byte);
            return;
         end
         // drop a stray byte
         if (!frame_busy)
            return;
         b = it.data_byte;
         if (mode_model == MODE_WS) begin
            b = b ^ key_byte_at(held_key, key_phase);
            key_phase = key_phase + 2'd1;
         end
         due_byte(b, it.final_byte);
         if (it.final_byte)
            frame_busy = 1'b0;
         return;
      end
      if (raw) begin
         frame_busy = 1'b0;
         return;
      end
      for (int i = 0; i < WS_META_LEN; i++)
         meta[i] = 8'h00;
      for (int i = 0; i < 4; i++) begin
         meta[i]     = 8'(it.packet_id >> (24 - 8 * i));
         meta[4 + i] = 8'(it.stream_number >> (24 - 8 * i));
      end
      meta[8]  = it.packet_kind;
      meta[9]  = it.packet_flag_bits[15:8];
      meta[10] = it.packet_flag_bits[7:0];
      if (mode_model == MODE_WS) begin
         ws_total = 64'(it.payload_length) + 64'(WS_META_LEN);
         due_byte(WS_FIRST_BYTE, 1'b0);
         if (ws_total < 64'(SHORT_LIMIT)) begin
            due_byte({WS_MASK_BIT, ws_total[6:0]}, 1'b0);
         end else if (ws_total < 64'(MID_LIMIT)) begin
            due_byte({WS_MASK_BIT, LEN16_CODE}, 1'b0);
            due_byte(ws_total[15:8], 1'b0);
            due_byte(ws_total[7:0], 1'b0);
         end else begin
            due_byte({WS_MASK_BIT, LEN64_CODE}, 1'b0);
            for (int i = 0; i < 8; i++)
               due_byte(8'(ws_total >> (56 - 8 * i)), 1'b0);
         end
         for (int i = 0; i < 4; i++)
            due_byte(key_byte_at(it.mask_value, 2'(i)), 1'b0);
         for (int i = 0; i < WS_META_LEN; i++)
            due_byte(meta[i] ^ key_byte_at(it.mask_value, 2'(i)),
                     (it.payload_length == 0) && (i == WS_META_LEN - 1));
         held_key  = it.mask_value;
         key_phase = 2'(WS_META_LEN);
      end else begin
         grpc_total = it.payload_length + 32'(GRPC_META_LEN);
         due_byte(8'h00, 1'b0);
         for (int i = 0; i < 4; i++)
            due_byte(8'(grpc_total >> (24 - 8 * i)), 1'b0);
         for (int i = 0; i < GRPC_META_LEN; i++)
            due_byte(meta[i], (it.payload_length == 0) && (i == GRPC_META_LEN - 1));
      end
      frame_busy = (it.payload_length != 0);
   endtask

   // Request driver: bursts of transfers separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            encode_request(current_item);
         if (!req_valid || req_ready) begin
            if (gap_left > 0 || pending_items.size() == 0) begin
               if (gap_left > 0)
                  gap_left--;
               req_valid <= 1'b0;
            end else begin
               current_item = pending_items.pop_front();
               req_valid            <= 1'b1;
               req_action           <= current_item.action;
               req_payload_length   <= current_item.payload_length;
               req_mask_value       <= current_item.mask_value;
               req_packet_id        <= current_item.packet_id;
               req_stream_number    <= current_item.stream_number;
               req_packet_kind      <= current_item.packet_kind;
               req_packet_flag_bits <= current_item.packet_flag_bits;
               req_data_byte        <= current_item.data_byte;
               req_final_byte       <= current_item.final_byte;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 16);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
   end

   // Response monitor and receiver stall pattern.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (frame_bytes_due.size() == 0) begin
               report_mismatch($sformatf("unexpected transfer byte %h end %b",
                                         rsp_out_byte, rsp_frame_end));
            end else begin
               oldest_due = frame_bytes_due.pop_front();
               if (rsp_out_byte !== oldest_due.value)
                  report_mismatch($sformatf("out_byte %h, expected %h",
                                            rsp_out_byte, oldest_due.value));
               if (rsp_frame_end !== oldest_due.last)
                  report_mismatch($sformatf("frame_end %b, expected %b (byte %h)",
                                            rsp_frame_end, oldest_due.last, oldest_due.value));
            end
         end
         if (hold_left == 0 && holds_served != holds_requested) begin
            hold_left = LONG_HOLD;
            holds_served++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (pattern_left == 0) begin
               stall_style  = stall_style_type'($urandom_range(0, 3));
               pattern_left = $urandom_range(16, 96);
            end else begin
               pattern_left--;
            end
            stall_step++;
            case (stall_style)
               STALL_NONE:        rsp_ready <= 1'b1;
               STALL_LIGHT:       rsp_ready <= ($urandom_range(0, 3) != 0);
               STALL_EVERY_THIRD: rsp_ready <= (stall_step % 3 != 0);
               default:           rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   initial begin : watchdog
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   task automatic queue_descriptor(input logic [31:0] len, input logic [31:0] key,
                                   input logic [31:0] id, input logic [31:0] stream,
                                   input logic [7:0] kind, input logic [15:0] flags);
      tunnel_item_type it;
      it.action           = ACT_DESCRIPTOR;
      it.payload_length   = len;
      it.mask_value       = key;
      it.packet_id        = id;
      it.stream_number    = stream;
      it.packet_kind      = kind;
      it.packet_flag_bits = flags;
      it.data_byte        = 8'($urandom);
      it.final_byte       = 1'($urandom);
      pending_items = {pending_items, it};
   endtask

   task automatic queue_random_descriptor(input logic [31:0] len);
      queue_descriptor(len, $urandom, $urandom, $urandom, 8'($urandom), 16'($urandom));
   endtask

   task automatic queue_payload(input logic [7:0] data, input logic last);
      tunnel_item_type it;
      it.action           = ACT_PAYLOAD;
      it.payload_length   = $urandom;
      it.mask_value       = $urandom;
      it.packet_id        = $urandom;
      it.stream_number    = $urandom;
      it.packet_kind      = 8'($urandom);
      it.packet_flag_bits = 16'($urandom);
      it.data_byte        = data;
      it.final_byte       = last;
      pending_items = {pending_items, it};
   endtask

   // Mostly whole frames with random content; some stray bytes and frames
   // that never see their final byte.
   task automatic queue_random_traffic(input int target);
      int          queued;
      int          nbytes;
      int          pick;
      logic [31:0] len;
      queued = 0;
      while (queued < target) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            queue_payload(8'($urandom), 1'($urandom));
            queued++;
         end else begin
            nbytes = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
            case ($urandom_range(0, 9))
               0:       len = $urandom;
               1:       len = $urandom_range(98, 110);
               2:       len = $urandom_range(65508, 65520);
               default: len = nbytes;
            endcase
            queue_random_descriptor(len);
            for (int i = 0; i < nbytes; i++)
               queue_payload(8'($urandom), (i == nbytes - 1) && (pick != 1));
            queued += nbytes + 1;
         end
      end
   endtask

   task automatic wait_idle();
      while (pending_items.size() != 0 || req_valid || frame_bytes_due.size() != 0)
         @(posedge clock);
      // let items that produce nothing clear the block
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_mode(input logic [1:0] mode);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= mode;
      @(posedge clock);
      mode_model = mode;
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // WebSocket: empty frames, length form boundaries, stray byte,
      // abandoned frame
      set_mode(MODE_WS);
      queue_descriptor(32'd0, '0, '0, '0, '0, '0);
      queue_descriptor(32'd0, '1, '1, '1, '1, '1);
      queue_payload(8'hFF, 1'b1);
      queue_random_descriptor(32'd103);
      queue_payload(8'h00, 1'b1);
      queue_random_descriptor(32'd104);
      queue_payload(8'hFF, 1'b1);
      queue_random_descriptor(32'd65513);
      queue_payload(8'h5A, 1'b1);
      queue_random_descriptor(32'd65514);
      queue_payload(8'hA5, 1'b1);
      queue_random_descriptor(32'hFFFF_FFFF);
      queue_payload(8'h3C, 1'b0);
      queue_random_descriptor(32'd2);
      queue_payload(8'h00, 1'b0);
      queue_payload(8'hFF, 1'b1);
      queue_random_traffic(70);
      holds_requested++;

      // gRPC: empty frame, length wrap, stray byte
      set_mode(MODE_GRPC);
      queue_descriptor(32'd0, '1, '1, '1, '1, '1);
      queue_random_descriptor(32'hFFFF_FFFF);
      queue_payload(8'hFF, 1'b1);
      queue_payload(8'h12, 1'b1);
      queue_random_traffic(60);

      // pass-through: descriptors vanish, bytes go out unchanged
      set_mode(MODE_RAW);
      queue_random_descriptor(32'd5);
      queue_payload(8'h00, 1'b0);
      queue_payload(8'hFF, 1'b1);
      queue_random_traffic(40);

      set_mode(MODE_RAW_ALT);
      queue_random_traffic(40);

      // one frame carried across mode changes
      set_mode(MODE_WS);
      queue_random_descriptor(32'd10);
      queue_payload(8'h11, 1'b0);
      queue_payload(8'h22, 1'b0);
      set_mode(MODE_GRPC);
      queue_payload(8'h33, 1'b0);
      set_mode(MODE_RAW_ALT);
      queue_payload(8'h44, 1'b1);
      set_mode(MODE_WS);
      queue_payload(8'h55, 1'b0);
      queue_payload(8'h66, 1'b1);
      queue_random_traffic(70);

      set_mode(MODE_GRPC);
      queue_random_traffic(60);
      holds_requested++;

      wait_idle();
      if (frame_bytes_due.size() != 0)
         report_mismatch($sformatf("%0d expected bytes never arrived", frame_bytes_due.size()));
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/tfe_pkg.sv
hw/rtl/tfe_front.sv
hw/rtl/tfe_fifo.sv
hw/rtl/tfe_back.sv
hw/rtl/tunnel_frame_encoder.sv
bench/tb_tunnel_frame_encoder.sv
